@@ design/sublpf_pkg.sv @@
// ----------------------------------------------------------------------------
// sublpf_pkg
// Shared types and constants for the subwoofer low-pass biquad cascade.
// ----------------------------------------------------------------------------
package sublpf_pkg;

	localparam int MUL_W      = 33;            // signed operand width of the shared multiplier
	localparam int PROD_W     = 2 * MUL_W;     // width of one partial product
	localparam int FULL_W     = 98;            // width of a reassembled 64 x 32 product
	localparam int STATE_W    = 64;            // delay word and running sum width, Q16.48
	localparam int FRAC_STATE = 48;
	localparam int HALF_W     = 32;            // one half of a packed coefficient register
	localparam int GAIN_W     = 48;
	localparam int CHAN_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEC1_FB     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEC1_FF     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEC2_FB     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SEC2_FF     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SUB_CHANNEL = 3'd5;

	localparam logic [CHAN_W-1:0] SUB_CHANNEL_RESET = 3'd5;

	// One product per operation, each split into a low and a high half pass.
	localparam int NUM_OPS   = 9;
	localparam int STEP_W    = 5;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2 * NUM_OPS - 1);

	typedef enum logic [3:0] {
		OP_GAIN  = 4'd0,
		OP_S1_A1 = 4'd1,
		OP_S1_A2 = 4'd2,
		OP_S1_B1 = 4'd3,
		OP_S1_B2 = 4'd4,
		OP_S2_A1 = 4'd5,
		OP_S2_A2 = 4'd6,
		OP_S2_B1 = 4'd7,
		OP_S2_B2 = 4'd8
	} prod_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT
	} ctl_state_t;

	typedef struct packed {
		logic     load;      // capture the input frame
		logic     issue;     // start one partial product
		prod_op_t op;
		logic     half;      // 0: low half pass, 1: high half pass
		logic     out_load;  // move the finished sample into the output register
	} dp_cmd_t;

	typedef struct packed {
		logic fin;       // running sum holds the filtered sample
		logic out_free;  // output register can take a sample this cycle
	} dp_status_t;

endpackage

@@ design/sublpf_ctrl.sv @@
// ----------------------------------------------------------------------------
// sublpf_ctrl
// Sequencer that steps the shared multiplier through the nine products.
// ----------------------------------------------------------------------------
module sublpf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  sublpf_pkg::dp_status_t status,
	output sublpf_pkg::dp_cmd_t    cmd
);

	sublpf_pkg::ctl_state_t state_q, state_d;
	logic [sublpf_pkg::STEP_W-1:0] step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sublpf_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		step_d       = step_q;
		s_tready     = 1'b0;
		cmd.load     = 1'b0;
		cmd.issue    = 1'b0;
		cmd.op       = sublpf_pkg::prod_op_t'(step_q[sublpf_pkg::STEP_W-1:1]);
		cmd.half     = step_q[0];
		cmd.out_load = 1'b0;
		case (state_q)
			sublpf_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				step_d   = '0;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = sublpf_pkg::ST_RUN;
				end
			end
			sublpf_pkg::ST_RUN: begin
				cmd.issue = 1'b1;
				if (step_q == sublpf_pkg::LAST_STEP) begin
					state_d = sublpf_pkg::ST_WAIT;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			sublpf_pkg::ST_WAIT: begin
				if (status.fin && status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = sublpf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sublpf_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ design/sublpf_datapath.sv @@
// ----------------------------------------------------------------------------
// sublpf_datapath
// Configuration registers, delay words, shared 33 x 33 multiplier with its
// reassembly, scaling and saturation stages, and the output register.
// ----------------------------------------------------------------------------
module sublpf_datapath #(
	parameter int SAMPLE_WIDTH = 24,
	parameter int COEF_WIDTH   = 32,
	parameter int IN_TDATA_W   = 48,
	parameter int OUT_TDATA_W  = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [sublpf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sublpf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic [IN_TDATA_W-1:0]               s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [OUT_TDATA_W-1:0]              m_tdata,
	output logic [sublpf_pkg::CHAN_W-1:0]       m_tuser,
	input  sublpf_pkg::dp_cmd_t                 cmd,
	output sublpf_pkg::dp_status_t              status
);

	localparam int MW      = sublpf_pkg::MUL_W;
	localparam int PW      = sublpf_pkg::PROD_W;
	localparam int FW      = sublpf_pkg::FULL_W;
	localparam int SW      = sublpf_pkg::STATE_W;
	localparam int HW      = sublpf_pkg::HALF_W;
	localparam int FRAC_IN = SAMPLE_WIDTH - 1;
	localparam int FRAC_CO = COEF_WIDTH - 2;
	localparam int OUT_SH  = sublpf_pkg::FRAC_STATE - FRAC_IN;

	// Configuration registers.
	logic [sublpf_pkg::GAIN_W-1:0]     gain_q;
	logic [sublpf_pkg::CFG_DATA_W-1:0] s1_fb_q, s1_ff_q, s2_fb_q, s2_ff_q;
	logic [sublpf_pkg::CHAN_W-1:0]     chan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= '0;
			s1_fb_q <= '0;
			s1_ff_q <= '0;
			s2_fb_q <= '0;
			s2_ff_q <= '0;
			chan_q  <= sublpf_pkg::SUB_CHANNEL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				sublpf_pkg::REG_GAIN:        gain_q  <= cfg_wdata[sublpf_pkg::GAIN_W-1:0];
				sublpf_pkg::REG_SEC1_FB:     s1_fb_q <= cfg_wdata;
				sublpf_pkg::REG_SEC1_FF:     s1_ff_q <= cfg_wdata;
				sublpf_pkg::REG_SEC2_FB:     s2_fb_q <= cfg_wdata;
				sublpf_pkg::REG_SEC2_FF:     s2_ff_q <= cfg_wdata;
				sublpf_pkg::REG_SUB_CHANNEL: chan_q  <= cfg_wdata[sublpf_pkg::CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	function automatic logic signed [MW-1:0] coef_ext(input logic [HW-1:0] c);
		coef_ext = {{(MW - COEF_WIDTH){c[COEF_WIDTH-1]}}, c[COEF_WIDTH-1:0]};
	endfunction

	function automatic logic signed [SW-1:0] sat_add(input logic signed [SW-1:0] a,
	                                                  input logic signed [SW-1:0] b);
		logic signed [SW:0] r;
		r = {a[SW-1], a} + {b[SW-1], b};
		if (r[SW] != r[SW-1]) begin
			sat_add = r[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		end else begin
			sat_add = r[SW-1:0];
		end
	endfunction

	function automatic logic signed [SW-1:0] sat_sub(input logic signed [SW-1:0] a,
	                                                  input logic signed [SW-1:0] b);
		logic signed [SW:0] r;
		r = {a[SW-1], a} - {b[SW-1], b};
		if (r[SW] != r[SW-1]) begin
			sat_sub = r[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		end else begin
			sat_sub = r[SW-1:0];
		end
	endfunction

	// Input frame: the floored average is the sum without its lowest bit.
	logic signed [SAMPLE_WIDTH:0]   frame_sum;
	logic signed [SAMPLE_WIDTH-1:0] x_q;

	assign frame_sum = {s_tdata[SAMPLE_WIDTH-1], s_tdata[SAMPLE_WIDTH-1:0]}
	                 + {s_tdata[2*SAMPLE_WIDTH-1], s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= frame_sum[SAMPLE_WIDTH:1];
		end
	end

	// Delay words: section one h0/h1 and section two h0/h1.
	logic signed [SW-1:0] s1h0_q, s1h1_q, s2h0_q, s2h1_q;

	// Operand selection. A delay word is split into halves; the gain is split
	// into a 32-bit low part and a 16-bit high part.
	logic [SW-1:0]        h_sel;
	logic [HW-1:0]        c_sel;
	logic signed [MW-1:0] mul_a, mul_b;

	always_comb begin
		h_sel = s1h0_q;
		c_sel = s1_fb_q[2*HW-1:HW];
		case (cmd.op)
			sublpf_pkg::OP_S1_A1: begin h_sel = s1h0_q; c_sel = s1_fb_q[2*HW-1:HW]; end
			sublpf_pkg::OP_S1_A2: begin h_sel = s1h1_q; c_sel = s1_fb_q[HW-1:0];    end
			sublpf_pkg::OP_S1_B1: begin h_sel = s1h0_q; c_sel = s1_ff_q[2*HW-1:HW]; end
			sublpf_pkg::OP_S1_B2: begin h_sel = s1h1_q; c_sel = s1_ff_q[HW-1:0];    end
			sublpf_pkg::OP_S2_A1: begin h_sel = s2h0_q; c_sel = s2_fb_q[2*HW-1:HW]; end
			sublpf_pkg::OP_S2_A2: begin h_sel = s2h1_q; c_sel = s2_fb_q[HW-1:0];    end
			sublpf_pkg::OP_S2_B1: begin h_sel = s2h0_q; c_sel = s2_ff_q[2*HW-1:HW]; end
			sublpf_pkg::OP_S2_B2: begin h_sel = s2h1_q; c_sel = s2_ff_q[HW-1:0];    end
			default: ;
		endcase
		if (cmd.op == sublpf_pkg::OP_GAIN) begin
			mul_a = {{(MW - SAMPLE_WIDTH){x_q[SAMPLE_WIDTH-1]}}, x_q};
			mul_b = cmd.half
			      ? {{(MW - (sublpf_pkg::GAIN_W - HW)){1'b0}}, gain_q[sublpf_pkg::GAIN_W-1:HW]}
			      : {1'b0, gain_q[HW-1:0]};
		end else begin
			mul_a = cmd.half ? {h_sel[SW-1], h_sel[SW-1:HW]} : {1'b0, h_sel[HW-1:0]};
			mul_b = coef_ext(c_sel);
		end
	end

	// Stage 1: partial product.
	logic                   v_s1, half_s1;
	sublpf_pkg::prod_op_t   op_s1;
	logic signed [PW-1:0]   prod_s1, lo_q;
	// Stage 2: reassembled full product.
	logic                   v_s2;
	sublpf_pkg::prod_op_t   op_s2;
	logic signed [FW-1:0]   full_s2;
	// Stage 3: scaled and saturated product.
	logic                   v_s3;
	sublpf_pkg::prod_op_t   op_s3;
	logic signed [SW-1:0]   p_s3;

	logic signed [FW-1:0] full_d, shifted;
	logic signed [SW-1:0] p_d;

	assign full_d = {{(FW - PW){lo_q[PW-1]}}, lo_q}
	              + ({{(FW - PW){prod_s1[PW-1]}}, prod_s1} <<< HW);

	always_comb begin
		shifted = (op_s2 == sublpf_pkg::OP_GAIN) ? (full_s2 >>> FRAC_IN) : (full_s2 >>> FRAC_CO);
		if ((&shifted[FW-1:SW-1]) || !(|shifted[FW-1:SW-1])) begin
			p_d = shifted[SW-1:0];
		end else begin
			p_d = shifted[FW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1 && half_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		op_s1   <= cmd.op;
		half_s1 <= cmd.half;
		if (v_s1 && !half_s1) begin
			lo_q <= prod_s1;
		end
		full_s2 <= full_d;
		op_s2   <= op_s1;
		p_s3    <= p_d;
		op_s3   <= op_s2;
	end

	// Stage 4: the running sum carries u, hn and out through both sections.
	logic signed [SW-1:0] sum_q, hn_q;
	logic                 fin_q;

	always_ff @(posedge clk) begin
		if (v_s3) begin
			case (op_s3)
				sublpf_pkg::OP_GAIN: sum_q <= p_s3;
				sublpf_pkg::OP_S1_A1, sublpf_pkg::OP_S2_A1: sum_q <= sat_sub(sum_q, p_s3);
				sublpf_pkg::OP_S1_A2, sublpf_pkg::OP_S2_A2: begin
					sum_q <= sat_sub(sum_q, p_s3);
					hn_q  <= sat_sub(sum_q, p_s3);
				end
				default: sum_q <= sat_add(sum_q, p_s3);
			endcase
		end
	end

	// A section's delay words shift once its last product has been used.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1h0_q <= '0;
			s1h1_q <= '0;
			s2h0_q <= '0;
			s2h1_q <= '0;
			fin_q  <= 1'b0;
		end else begin
			if (v_s3 && op_s3 == sublpf_pkg::OP_S1_B2) begin
				s1h1_q <= s1h0_q;
				s1h0_q <= hn_q;
			end
			if (v_s3 && op_s3 == sublpf_pkg::OP_S2_B2) begin
				s2h1_q <= s2h0_q;
				s2h0_q <= hn_q;
				fin_q  <= 1'b1;
			end else if (cmd.out_load) begin
				fin_q <= 1'b0;
			end
		end
	end

	// Output scaling by a floor shift and saturation, then the output register.
	logic signed [SW-1:0]           z_sh;
	logic signed [SAMPLE_WIDTH-1:0] z_sat;
	logic [SAMPLE_WIDTH-1:0]        out_sample_q;
	logic [sublpf_pkg::CHAN_W-1:0]  out_chan_q;
	logic                           out_valid_q;

	always_comb begin
		z_sh = sum_q >>> OUT_SH;
		if ((&z_sh[SW-1:SAMPLE_WIDTH-1]) || !(|z_sh[SW-1:SAMPLE_WIDTH-1])) begin
			z_sat = z_sh[SAMPLE_WIDTH-1:0];
		end else begin
			z_sat = z_sh[SW-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
			                   : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_sample_q <= z_sat;
			out_chan_q   <= chan_q;
		end
	end

	assign m_tvalid        = out_valid_q;
	assign m_tdata         = {{(OUT_TDATA_W - SAMPLE_WIDTH){1'b0}}, out_sample_q};
	assign m_tuser         = out_chan_q;
	assign status.fin      = fin_q;
	assign status.out_free = !out_valid_q || m_tready;

endmodule

@@ design/subwoofer_lowpass_biquad_cascade.sv @@
// ----------------------------------------------------------------------------
// subwoofer_lowpass_biquad_cascade
// Stereo-to-mono scaling followed by two saturating biquad sections.
// The single shared 33 x 33 multiplier does two half passes for each of the
// nine products; a new frame is taken only after the previous sample has
// moved into the output register.
// Reset clears the delay words and configuration registers (sub_channel to 5) at once.
// ----------------------------------------------------------------------------
module subwoofer_lowpass_biquad_cascade #(
	parameter int SAMPLE_WIDTH = 24,
	parameter int COEF_WIDTH   = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [sublpf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sublpf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// left_sample, then right_sample, zero padded to whole bytes
	input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// sub_sample, zero padded to whole bytes
	output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,
	// target_channel
	output logic [sublpf_pkg::CHAN_W-1:0]     m_tuser
);

	localparam int IN_TDATA_W  = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

	sublpf_pkg::dp_cmd_t    cmd;
	sublpf_pkg::dp_status_t status;

	sublpf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	sublpf_datapath #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COEF_WIDTH   (COEF_WIDTH),
		.IN_TDATA_W   (IN_TDATA_W),
		.OUT_TDATA_W  (OUT_TDATA_W)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.status    (status)
	);

	// Only one frame is in the filter at a time.
	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("frame transfer accepted while the filter was busy");

	// A finished sample is only moved into a free output register.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (status.fin && status.out_free))
		else $error("output register loaded without a finished sample or room");

	// No new product is started while the finished sample waits.
	a_no_issue_at_fin: assert property (@(posedge clk) disable iff (!arst_n)
		status.fin |-> !cmd.issue)
		else $error("multiplier issued while the result was pending");

endmodule

@@ tb/tb_subwoofer_lowpass_biquad_cascade.sv @@
// ----------------------------------------------------------------------------
// tb_subwoofer_lowpass_biquad_cascade
// Drives stereo frames through the subwoofer low-pass cascade and checks
// every mono sample and channel slot against a cycle-free model of the
// saturating fixed-point filter. Directed tests cover register decoding,
// sample extremes and filter overflow. Random traffic then runs under
// several coefficient sets; both stream sides stall at random except in the last run.
// ----------------------------------------------------------------------------
module tb_subwoofer_lowpass_biquad_cascade;

	localparam int SAMPLE_W  = 24;
	localparam int IN_FRAC   = SAMPLE_W - 1;
	localparam int COEF_FRAC = 30;
	localparam int OUT_SHIFT = sublpf_pkg::FRAC_STATE - IN_FRAC;
	localparam int DRAIN_CYCLES = 30;
	localparam longint RUN_LIMIT = 64'd12_000_000;

	localparam logic [sublpf_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [sublpf_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	localparam longint STATE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint STATE_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [SAMPLE_W-1:0] PCM_MAX = 24'sh7F_FFFF;
	localparam logic signed [SAMPLE_W-1:0] PCM_MIN = 24'sh80_0000;
	localparam logic [sublpf_pkg::HALF_W-1:0] COEF_MINUS_TWO = 32'h8000_0000;
	localparam logic [sublpf_pkg::HALF_W-1:0] COEF_PLUS_TWO  = 32'h7FFF_FFFF;
	localparam logic [sublpf_pkg::HALF_W-1:0] COEF_ONE       = 32'h4000_0000;

	typedef struct {
		logic [SAMPLE_W-1:0]           sub_sample;
		logic [sublpf_pkg::CHAN_W-1:0] target_channel;
	} sub_result_t;

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_we;
	logic [sublpf_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [sublpf_pkg::CFG_DATA_W-1:0] cfg_wdata;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [47:0]                       s_tdata;   // left_sample, right_sample
	logic                              m_tvalid;
	logic                              m_tready;
	logic [23:0]                       m_tdata;   // sub_sample
	logic [sublpf_pkg::CHAN_W-1:0]     m_tuser;   // target_channel

	// Shadow registers and delay words of the filter as the testbench sees them.
	logic [sublpf_pkg::GAIN_W-1:0]  gain_q48;
	logic [sublpf_pkg::STATE_W-1:0] s1_feedback, s1_feedforward, s2_feedback, s2_feedforward;
	logic [sublpf_pkg::CHAN_W-1:0]  sub_slot;
	longint                         delay_q48 [4];

	sub_result_t           expected_subs [$];
	int                    error_count;
	int                    tx_idle_pct;
	int                    rx_idle_pct;
	logic signed [SAMPLE_W-1:0] walk_left, walk_right;

	subwoofer_lowpass_biquad_cascade DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// ------------------------------------------------------------------
	// Fixed-point model
	// ------------------------------------------------------------------

	// Full product, shifted right with floor, clamped to the 64-bit range.
	function automatic longint mul_floor_sat(longint a, longint b, int sh);
		logic signed [127:0] wa, wb, prod;
		wa = a;
		wb = b;
		prod = (wa * wb) >>> sh;
		if (prod[127:63] == {65{1'b0}} || prod[127:63] == {65{1'b1}})
			return prod[63:0];
		return prod[127] ? STATE_MIN : STATE_MAX;
	endfunction

	function automatic longint add_sat(longint a, longint b);
		logic signed [64:0] sum;
		sum = a + b;
		if (sum[64] != sum[63])
			return sum[64] ? STATE_MIN : STATE_MAX;
		return sum[63:0];
	endfunction

	function automatic longint sub_sat(longint a, longint b);
		logic signed [64:0] diff;
		diff = a - b;
		if (diff[64] != diff[63])
			return diff[64] ? STATE_MIN : STATE_MAX;
		return diff[63:0];
	endfunction

	// One direct-form-II section; base selects its pair of delay words.
	function automatic longint biquad_step(longint x, logic [63:0] fb, logic [63:0] ff,
			int base);
		logic signed [sublpf_pkg::HALF_W-1:0] a1, a2, b1, b2;
		longint h0, h1, hn;
		a1 = fb[63:32];
		a2 = fb[31:0];
		b1 = ff[63:32];
		b2 = ff[31:0];
		h0 = delay_q48[base];
		h1 = delay_q48[base+1];
		hn = sub_sat(sub_sat(x, mul_floor_sat(h0, longint'(a1), COEF_FRAC)),
			mul_floor_sat(h1, longint'(a2), COEF_FRAC));
		delay_q48[base+1] = h0;
		delay_q48[base] = hn;
		return add_sat(add_sat(hn, mul_floor_sat(h0, longint'(b1), COEF_FRAC)),
			mul_floor_sat(h1, longint'(b2), COEF_FRAC));
	endfunction

	function automatic logic [SAMPLE_W-1:0] filter_frame(logic signed [SAMPLE_W-1:0] left,
			logic signed [SAMPLE_W-1:0] right);
		longint mono, scaled, mid, low, shifted;
		mono = (longint'(left) + longint'(right)) >>> 1;
		scaled = mul_floor_sat(mono, longint'({16'd0, gain_q48}), IN_FRAC);
		mid = biquad_step(scaled, s1_feedback, s1_feedforward, 0);
		low = biquad_step(mid, s2_feedback, s2_feedforward, 2);
		shifted = low >>> OUT_SHIFT;
		if (shifted > longint'(PCM_MAX))
			shifted = longint'(PCM_MAX);
		if (shifted < longint'(PCM_MIN))
			shifted = longint'(PCM_MIN);
		return shifted[SAMPLE_W-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Driving and checking
	// ------------------------------------------------------------------

	task automatic report_error(string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic write_reg(logic [sublpf_pkg::CFG_IDX_W-1:0] idx,
			logic [sublpf_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			sublpf_pkg::REG_GAIN:        gain_q48 = value[sublpf_pkg::GAIN_W-1:0];
			sublpf_pkg::REG_SEC1_FB:     s1_feedback = value;
			sublpf_pkg::REG_SEC1_FF:     s1_feedforward = value;
			sublpf_pkg::REG_SEC2_FB:     s2_feedback = value;
			sublpf_pkg::REG_SEC2_FF:     s2_feedforward = value;
			sublpf_pkg::REG_SUB_CHANNEL: sub_slot = value[sublpf_pkg::CHAN_W-1:0];
			default: ;
		endcase
	endtask

	// Leaves tvalid high after the transfer so back-to-back frames need no
	// second assignment in one step; drain_filter lowers it.
	task automatic send_frame(logic signed [SAMPLE_W-1:0] left,
			logic signed [SAMPLE_W-1:0] right);
		sub_result_t res;
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= 48'({$urandom, $urandom});
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {right, left};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		res.sub_sample = filter_frame(left, right);
		res.target_channel = sub_slot;
		expected_subs.push_back(res);
	endtask

	task automatic drain_filter();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_subs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

	always @(posedge clk) begin
		sub_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_subs.size() == 0) begin
				report_error($sformatf("unexpected sample 0x%06h slot %0d", m_tdata, m_tuser));
			end else begin
				want = expected_subs.pop_front();
				if (m_tdata !== want.sub_sample)
					report_error($sformatf("sub_sample got 0x%06h expected 0x%06h",
						m_tdata, want.sub_sample));
				if (m_tuser !== want.target_channel)
					report_error($sformatf("target_channel got %0d expected %0d",
						m_tuser, want.target_channel));
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Zero gain after reset: silence on slot five whatever comes in.
	task automatic test_reset_state();
		send_frame(24'sd0, 24'sd0);
		send_frame(PCM_MAX, PCM_MAX);
		send_frame(PCM_MIN, PCM_MIN);
		send_frame(PCM_MAX, PCM_MIN);
		drain_filter();
	endtask

	// Spare indexes must not disturb anything and wide data is truncated.
	task automatic test_register_map();
		write_reg(REG_SPARE_6, '1);
		write_reg(REG_SPARE_7, '1);
		write_reg(sublpf_pkg::REG_GAIN, '1);
		write_reg(sublpf_pkg::REG_SUB_CHANNEL, 64'hFFFF_FFFF_FFFF_FFF8);
		send_frame(PCM_MAX, PCM_MAX);
		send_frame(PCM_MIN, PCM_MIN);
		send_frame(PCM_MAX, PCM_MIN);
		send_frame(24'sd1, 24'sd0);
		send_frame(-24'sd1, 24'sd0);
		send_frame(PCM_MIN, -24'sd1);
		drain_filter();
		write_reg(sublpf_pkg::REG_SUB_CHANNEL, 64'd7);
		send_frame(24'sd12345, -24'sd54321);
		drain_filter();
	endtask

	// Coefficients far outside the stable region drive the delay words into
	// saturation; clearing the feedback then flushes them within two frames.
	task automatic test_filter_overflow();
		write_reg(sublpf_pkg::REG_SEC1_FB, {COEF_MINUS_TWO, COEF_MINUS_TWO});
		write_reg(sublpf_pkg::REG_SEC1_FF, {COEF_PLUS_TWO, COEF_PLUS_TWO});
		write_reg(sublpf_pkg::REG_SEC2_FB, {COEF_PLUS_TWO, COEF_MINUS_TWO});
		write_reg(sublpf_pkg::REG_SEC2_FF, {COEF_MINUS_TWO, COEF_MINUS_TWO});
		for (int i = 0; i < 10; i++)
			send_frame((i % 2) ? PCM_MIN : PCM_MAX, (i % 3) ? PCM_MAX : PCM_MIN);
		drain_filter();
		write_reg(sublpf_pkg::REG_SEC1_FB, '0);
		write_reg(sublpf_pkg::REG_SEC1_FF, '0);
		write_reg(sublpf_pkg::REG_SEC2_FB, '0);
		write_reg(sublpf_pkg::REG_SEC2_FF, '0);
		send_frame(24'sd100, 24'sd200);
		send_frame(-24'sd300, 24'sd7);
		drain_filter();
	endtask

	function automatic logic [sublpf_pkg::HALF_W-1:0] pick_extreme_coef();
		case ($urandom_range(0, 3))
			0: return COEF_MINUS_TWO;
			1: return COEF_PLUS_TWO;
			2: return COEF_ONE;
			default: return '0;
		endcase
	endfunction

	// Feedback pair inside the stability triangle |a2| < 1, |a1| < 1 + a2.
	function automatic logic [63:0] stable_feedback();
		longint a2, a1;
		a2 = $urandom_range(0, 1020054733);
		a1 = $urandom_range(0, int'(((64'd1 << 30) + a2) * 15 / 16));
		if ($urandom_range(0, 3) != 0)
			a1 = -a1;
		return {a1[31:0], a2[31:0]};
	endfunction

	function automatic logic [63:0] modest_feedforward();
		logic signed [31:0] b1, b2;
		b1 = $signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000;
		b2 = $signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000;
		return {b1, b2};
	endfunction

	task automatic randomize_config();
		logic [sublpf_pkg::CFG_DATA_W-1:0] gain_word;
		int mode;
		mode = $urandom_range(0, 3);
		case ($urandom_range(0, 4))
			0: gain_word = '1;
			1: gain_word = '0;
			2: gain_word = 64'h8000_0000_0000;
			3: gain_word = {$urandom, $urandom} >> $urandom_range(16, 60);
			default: gain_word = {$urandom, $urandom};
		endcase
		write_reg(sublpf_pkg::REG_GAIN, gain_word);
		case (mode)
			0: begin
				write_reg(sublpf_pkg::REG_SEC1_FB, stable_feedback());
				write_reg(sublpf_pkg::REG_SEC1_FF, modest_feedforward());
				write_reg(sublpf_pkg::REG_SEC2_FB, stable_feedback());
				write_reg(sublpf_pkg::REG_SEC2_FF, modest_feedforward());
			end
			1: begin
				write_reg(sublpf_pkg::REG_SEC1_FB, {$urandom, $urandom});
				write_reg(sublpf_pkg::REG_SEC1_FF, {$urandom, $urandom});
				write_reg(sublpf_pkg::REG_SEC2_FB, {$urandom, $urandom});
				write_reg(sublpf_pkg::REG_SEC2_FF, {$urandom, $urandom});
			end
			2: begin
				write_reg(sublpf_pkg::REG_SEC1_FB, '0);
				write_reg(sublpf_pkg::REG_SEC1_FF, {$urandom, $urandom});
				write_reg(sublpf_pkg::REG_SEC2_FB, '0);
				write_reg(sublpf_pkg::REG_SEC2_FF, modest_feedforward());
			end
			default: begin
				write_reg(sublpf_pkg::REG_SEC1_FB, {pick_extreme_coef(), pick_extreme_coef()});
				write_reg(sublpf_pkg::REG_SEC1_FF, {pick_extreme_coef(), pick_extreme_coef()});
				write_reg(sublpf_pkg::REG_SEC2_FB, {pick_extreme_coef(), pick_extreme_coef()});
				write_reg(sublpf_pkg::REG_SEC2_FF, {pick_extreme_coef(), pick_extreme_coef()});
			end
		endcase
		write_reg(sublpf_pkg::REG_SUB_CHANNEL, {$urandom_range(0, 1) ? $urandom : 32'd0,
			29'($urandom), 3'($urandom_range(0, 7))});
		if ($urandom_range(0, 3) == 0)
			write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, {$urandom, $urandom});
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_extreme_sample();
		case ($urandom_range(0, 4))
			0: return PCM_MAX;
			1: return PCM_MIN;
			2: return 24'sd1;
			3: return -24'sd1;
			default: return 24'sd0;
		endcase
	endfunction

	// Mostly random frames, some rail values, some slowly moving signal.
	task automatic test_random_stream(int n_frames, int tx_pct, int rx_pct);
		int sent, burst;
		logic signed [SAMPLE_W-1:0] left, right;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		sent = 0;
		while (sent < n_frames) begin
			drain_filter();
			randomize_config();
			burst = $urandom_range(60, 240);
			for (int i = 0; i < burst && sent < n_frames; i++) begin
				case ($urandom_range(0, 9))
					0, 1: begin
						left = pick_extreme_sample();
						right = pick_extreme_sample();
					end
					2, 3: begin
						walk_left = walk_left + $signed(24'($urandom_range(0, 8191)) - 24'sd4096);
						walk_right = walk_right + $signed(24'($urandom_range(0, 8191)) - 24'sd4096);
						left = walk_left;
						right = walk_right;
					end
					default: begin
						left = 24'($urandom);
						right = 24'($urandom);
					end
				endcase
				send_frame(left, right);
				sent++;
			end
		end
		drain_filter();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		error_count = 0;
		tx_idle_pct = 16;
		rx_idle_pct = 78;
		walk_left = '0;
		walk_right = '0;
		gain_q48 = '0;
		s1_feedback = '0;
		s1_feedforward = '0;
		s2_feedback = '0;
		s2_feedforward = '0;
		sub_slot = sublpf_pkg::SUB_CHANNEL_RESET;
		foreach (delay_q48[i])
			delay_q48[i] = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_register_map();
		test_filter_overflow();
		test_random_stream(700, 16, 78);
		test_random_stream(700, 78, 16);
		test_random_stream(600, 0, 0);

		if (expected_subs.size() != 0)
			report_error($sformatf("%0d expected samples never arrived", expected_subs.size()));
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#(RUN_LIMIT);
		$display("Timeout waiting for the filter");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ files.f @@
design/sublpf_pkg.sv
design/sublpf_ctrl.sv
design/sublpf_datapath.sv
design/subwoofer_lowpass_biquad_cascade.sv
tb/tb_subwoofer_lowpass_biquad_cascade.sv
